// ===== design/nupm_pkg.sv =====
// Package for the nearest unvisited point match block: sizes, item and command types.
// No dependencies; imported by every module of the block except nupm_ram.
`timescale 1ns / 1ps

package nupm_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned LIM_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SQ_W        = 2 * COORD_BITS;
  localparam int unsigned DIST_W      = SQ_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic                  req_type;
    logic [5:0]            entry_index;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
  } req_t;

  typedef struct packed {
    logic [5:0] match_index;
    logic       found;
  } rsp_t;

  // Classified command handed from the front queue to the back engine
  typedef struct packed {
    req_kind_e             kind;
    logic [IDX_W-1:0]      idx;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } cmd_t;

endpackage

// ===== design/nupm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nupm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/nupm_front.sv =====
// Front part: accepts input items, classifies them into commands and queues them.
// Depends on nupm_pkg.
`timescale 1ns / 1ps

module nupm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nupm_pkg::req_t in_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output nupm_pkg::cmd_t cmd_o
);
  import nupm_pkg::*;

  cmd_t              store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;
  cmd_t              cmd_new;

  assign in_ready_o  = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = store_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Classify: kind from the request type, index cut to the table depth
  always_comb begin
    cmd_new.kind = (in_data_i.req_type == 1'b1) ? REQ_QUERY : REQ_LOAD;
    cmd_new.idx  = IDX_W'(in_data_i.entry_index);
    cmd_new.x    = in_data_i.point_x;
    cmd_new.y    = in_data_i.point_y;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== design/nupm_back.sv =====
// Back part: executes loads and queries against the entry table and visited marks.
// Depends on nupm_pkg and nupm_ram.
`timescale 1ns / 1ps

module nupm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  nupm_pkg::cmd_t               cmd_i,
  input  logic [nupm_pkg::CNT_W-1:0]   cell_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output nupm_pkg::rsp_t               out_data_o
);
  import nupm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        scan_q, scan_d;
  logic [LIM_W-1:0]        limit_q, limit_d;
  logic [COORD_BITS-1:0]   ref_x_q, ref_y_q;
  logic [MAX_ENTRIES-1:0]  visited_q, visited_d;

  logic                    p0_vld_q, p0_skip_q;
  logic [IDX_W-1:0]        p0_idx_q;
  logic                    p1_vld_q, p1_skip_q;
  logic [IDX_W-1:0]        p1_idx_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic                    p2_vld_q, p2_skip_q;
  logic [IDX_W-1:0]        p2_idx_q;
  logic [SQ_W-1:0]         sx_q, sy_q;

  logic                    have_q, have_d;
  logic [IDX_W-1:0]        best_idx_q;
  logic [DIST_W-1:0]       best_dist_q, cand_dist;
  logic                    better;

  logic                    out_valid_q, out_valid_d;
  rsp_t                    out_q;

  logic                    start_load, start_query, issue, finish;
  logic [2*COORD_BITS-1:0] rd_data;
  logic [COORD_BITS-1:0]   ex, ey;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign start_load  = cmd_valid_i && (state_q == ST_IDLE) && (cmd_i.kind == REQ_LOAD);
  assign start_query = cmd_valid_i && (state_q == ST_IDLE) && (cmd_i.kind == REQ_QUERY);
  assign issue       = (state_q == ST_SCAN);
  assign finish      = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  nupm_ram #(
    .WIDTH(2 * COORD_BITS),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (start_load),
    .waddr_i(cmd_i.idx),
    .wdata_i({cmd_i.x, cmd_i.y}),
    .re_i   (issue),
    .raddr_i(scan_q),
    .rdata_o(rd_data)
  );

  assign ex = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign ey = rd_data[COORD_BITS-1:0];

  assign cand_dist = DIST_W'(sx_q) + DIST_W'(sy_q);
  assign better    = p2_vld_q && !p2_skip_q && (!have_q || (cand_dist < best_dist_q));

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    limit_d   = limit_q;
    have_d    = have_q;
    visited_d = visited_q;
    case (state_q)
      ST_IDLE: begin
        if (start_load) begin
          visited_d[cmd_i.idx] = 1'b0;
        end else if (start_query) begin
          // Saturate the count at the table depth
          limit_d = (cell_count_i > CNT_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES)
                                                         : LIM_W'(cell_count_i);
          scan_d  = '0;
          have_d  = 1'b0;
          state_d = (limit_d == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (LIM_W'(scan_q) == limit_q - LIM_W'(1)) begin
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!p0_vld_q && !p1_vld_q && !p2_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish) begin
          if (have_q) begin
            visited_d[best_idx_q] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (better) begin
      have_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      limit_q     <= '0;
      have_q      <= 1'b0;
      visited_q   <= '0;
      p0_vld_q    <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      limit_q     <= limit_d;
      have_q      <= have_d;
      visited_q   <= visited_d;
      p0_vld_q    <= issue;
      p1_vld_q    <= p0_vld_q;
      p2_vld_q    <= p1_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath: read, absolute difference, squares, running minimum
  always_ff @(posedge clk_i) begin
    if (start_query) begin
      ref_x_q <= cmd_i.x;
      ref_y_q <= cmd_i.y;
    end
    p0_idx_q  <= scan_q;
    p0_skip_q <= visited_q[scan_q];
    p1_idx_q  <= p0_idx_q;
    p1_skip_q <= p0_skip_q;
    dx_q      <= (ref_x_q >= ex) ? ref_x_q - ex : ex - ref_x_q;
    dy_q      <= (ref_y_q >= ey) ? ref_y_q - ey : ey - ref_y_q;
    p2_idx_q  <= p1_idx_q;
    p2_skip_q <= p1_skip_q;
    sx_q      <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sy_q      <= SQ_W'(dy_q) * SQ_W'(dy_q);
    if (better) begin
      best_idx_q  <= p2_idx_q;
      best_dist_q <= cand_dist;
    end
    if (finish) begin
      out_q.found       <= have_q;
      out_q.match_index <= have_q ? 6'(best_idx_q) : 6'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/nearest_unvisited_point_match_top.sv =====
// Top level of the nearest unvisited point match block: cell count register,
// front queue and back engine. Depends on nupm_pkg, nupm_front and nupm_back.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i/in_ready_o   nupm_pkg::req_t (load or query item)
//  out       output     out_valid_o/out_ready_i nupm_pkg::rsp_t (one item per query)
//  cfg       input      cfg_we_i                cfg_wdata_i (cell_count, 7 bits)
//
//  A load item is written to the table by the back engine once it leaves the two-item queue.
//  A query item is taken from the queue, then scans cell_count entries (saturated at
//  64), one read per entry from the single table read port, drains the distance
//  pipeline, posts the result and marks the winner, if any, visited; with cell_count at 0
//  it skips the scan and the drain.
//  Reset clears the visited marks, the queue and cell_count; table contents stay
//  undefined until loaded, so there is no clearing pass.
//  A stalled output holds the back engine in its final state; the front queue keeps
//  accepting items until both of its slots are full.

module nearest_unvisited_point_match_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  nupm_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output nupm_pkg::rsp_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [nupm_pkg::CNT_W-1:0] cfg_wdata_i
);
  import nupm_pkg::*;

  logic [CNT_W-1:0] cell_count_q;
  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;

  // Searched entry count; the user must write it only while the block is idle (unchecked)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= '0;
    end else if (cfg_we_i) begin
      cell_count_q <= cfg_wdata_i;
    end
  end

  // Accept and classify items, queue them for the engine
  nupm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // Execute loads, scan for the nearest unvisited entry, register the result
  nupm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cell_count_i(cell_count_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/nupm_checker.sv =====
// Port-level checks for the nearest unvisited point match block, bound to its top.
// Depends on nupm_pkg and nearest_unvisited_point_match_top.
`timescale 1ns / 1ps

module nupm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input nupm_pkg::req_t             in_data_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input nupm_pkg::rsp_t             out_data_o
);
  import nupm_pkg::*;

  // A waiting input item stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item withdrawn or changed while waiting");

  // A stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // No match means index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.match_index == 6'd0)
    else $error("non-zero index without a match");

  // Reset leaves no result pending
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered straight after reset");

  // Reset leaves the input queue open
  assert property (@(posedge clk_i)
    !rst_ni |=> in_ready_o)
    else $error("input not ready straight after reset");

endmodule

bind nearest_unvisited_point_match_top nupm_checker u_nupm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for nearest_unvisited_point_match_top: directed table, then random phases.
// Depends on nupm_pkg and the block's RTL only; an in-bench model predicts every match item.
`timescale 1ns / 1ps

module tb_top;
  import nupm_pkg::*;

  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 220;
  // A load left in the two-item queue behind the last query can still be in flight
  // when the final match arrives, so the drain waits before a count write.
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;
  logic cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  always #4 clk_i = ~clk_i;

  nearest_unvisited_point_match_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Bench copy of the block's state: candidate table, visited marks and the count register
  logic [COORD_BITS-1:0] cand_x     [MAX_ENTRIES];
  logic [COORD_BITS-1:0] cand_y     [MAX_ENTRIES];
  bit                    cand_taken [MAX_ENTRIES];
  logic [CNT_W-1:0]      search_count;

  rsp_t pending_matches [$];

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int cycle_count;
  int n_items;
  int n_queries;
  int n_found;
  int n_settings;

  // One row of the directed table: either a count write or an item, with an optional
  // hand-typed match item that replaces the predicted one
  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] count;
    req_t             item;
    bit               typed;
    rsp_t             exp;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    err_count++;
  endtask

  // Search the first search_count entries (saturated) for the nearest unvisited one;
  // ties keep the lowest index. Mark the winner visited.
  function automatic rsp_t nearest_unvisited(input logic [COORD_BITS-1:0] qx,
                                             input logic [COORD_BITS-1:0] qy);
    rsp_t                  r;
    int                    lim;
    bit                    have;
    logic [COORD_BITS-1:0] dx, dy;
    logic [SQ_W-1:0]       sq_x, sq_y;
    logic [DIST_W-1:0]     d, best_d;
    r      = '0;
    have   = 1'b0;
    best_d = '0;
    lim    = (search_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(search_count);
    for (int i = 0; i < lim; i++) begin
      if (!cand_taken[i]) begin
        dx   = (qx >= cand_x[i]) ? qx - cand_x[i] : cand_x[i] - qx;
        dy   = (qy >= cand_y[i]) ? qy - cand_y[i] : cand_y[i] - qy;
        sq_x = SQ_W'(dx) * SQ_W'(dx);
        sq_y = SQ_W'(dy) * SQ_W'(dy);
        d    = DIST_W'(sq_x) + DIST_W'(sq_y);
        if (!have || d < best_d) begin
          have          = 1'b1;
          best_d        = d;
          r.match_index = i[5:0];
        end
      end
    end
    if (have) begin
      cand_taken[r.match_index] = 1'b1;
      r.found = 1'b1;
    end
    return r;
  endfunction

  // Present one item, hold it until accepted, then predict its effect
  task automatic send_item(input req_t it, input bit typed, input rsp_t typed_rsp);
    rsp_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    if (it.req_type == REQ_QUERY) begin
      r = nearest_unvisited(it.point_x, it.point_y);
      n_queries++;
      if (r.found) n_found++;
      pending_matches.push_back(typed ? typed_rsp : r);
    end else begin
      cand_x[it.entry_index]     = it.point_x;
      cand_y[it.entry_index]     = it.point_y;
      cand_taken[it.entry_index] = 1'b0;
    end
  endtask

  // Drop valid, wait for every match item and for any trailing load, then write the count
  task automatic set_cell_count(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    search_count  = value;
    n_settings++;
  endtask

  // Coordinates: a quarter fully random, a quarter at the extremes, the rest in a tiny
  // range so that equal distances and ties turn up often
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(3))
      0:       return COORD_BITS'($urandom);
      1:       return $urandom_range(1) ? '1 : '0;
      default: return COORD_BITS'($urandom_range(3));
    endcase
  endfunction

  function automatic req_t rand_item();
    req_t it;
    int   lim;
    lim            = (search_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(search_count);
    it.req_type    = $urandom_range(1) ? REQ_QUERY : REQ_LOAD;
    // Aim most loads inside the searched window so that they clear live marks
    if (lim > 0 && $urandom_range(3) != 0) it.entry_index = 6'($urandom_range(lim - 1));
    else                                   it.entry_index = 6'($urandom_range(63));
    it.point_x     = rand_coord();
    it.point_y     = rand_coord();
    return it;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CNT_W-1:0] n);
    dir_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.count  = n;
    return r;
  endfunction

  function automatic dir_row_t row_load(input logic [5:0] idx, input logic [15:0] x,
                                        input logic [15:0] y);
    dir_row_t r;
    r      = '{default: '0};
    r.item = '{req_type: REQ_LOAD, entry_index: idx, point_x: x, point_y: y};
    return r;
  endfunction

  function automatic dir_row_t row_query(input logic [15:0] x, input logic [15:0] y,
                                         input bit typed, input logic [5:0] idx,
                                         input logic hit);
    dir_row_t r;
    r       = '{default: '0};
    r.item  = '{req_type: REQ_QUERY, entry_index: '0, point_x: x, point_y: y};
    r.typed = typed;
    r.exp   = '{match_index: idx, found: hit};
    return r;
  endfunction

  // Receiver: check each accepted match item against the oldest expectation, then
  // decide whether to stall the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("match item with nothing expected: idx=%0d found=%0b",
                                  out_data_o.match_index, out_data_o.found));
      end else begin
        if (out_data_o.found !== pending_matches[0].found)
          report_mismatch($sformatf("found: got %0b, want %0b",
                                    out_data_o.found, pending_matches[0].found));
        if (out_data_o.match_index !== pending_matches[0].match_index)
          report_mismatch($sformatf("match_index: got %0d, want %0d",
                                    out_data_o.match_index, pending_matches[0].match_index));
        void'(pending_matches.pop_front());
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d match items outstanding",
               cycle_count, pending_matches.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_t fill;
    logic [CNT_W-1:0] n;

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    in_data_i      <= '0;
    out_ready_i    <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    cycle_count    = 0;
    err_count      = 0;
    n_items        = 0;
    n_queries      = 0;
    n_found        = 0;
    n_settings     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    search_count   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cand_x[i]     = '0;
      cand_y[i]     = '0;
      cand_taken[i] = 1'b0;
    end

    // Directed table. Entries are loaded before any count reaches them.
    dir_rows.push_back(row_cfg(0));
    // Empty window: nothing to match, at both coordinate extremes
    dir_rows.push_back(row_query(16'h0000, 16'h0000, 1, 0, 0));
    dir_rows.push_back(row_query(16'hFFFF, 16'hFFFF, 1, 0, 0));
    dir_rows.push_back(row_load(0,  16'h0000, 16'h0000));
    dir_rows.push_back(row_load(1,  16'hFFFF, 16'hFFFF));
    dir_rows.push_back(row_load(2,  16'h0000, 16'hFFFF));
    dir_rows.push_back(row_load(3,  16'hFFFF, 16'h0000));
    dir_rows.push_back(row_load(63, 16'h1234, 16'hABCD));
    dir_rows.push_back(row_cfg(4));
    // Far corner: the distance to entry 0 needs the carry bit
    dir_rows.push_back(row_query(16'hFFFF, 16'hFFFF, 1, 1, 1));
    dir_rows.push_back(row_query(16'h0000, 16'h0000, 1, 0, 1));
    // Entries 2 and 3 are equidistant from the centre: lowest index first
    dir_rows.push_back(row_query(16'h8000, 16'h8000, 1, 2, 1));
    dir_rows.push_back(row_query(16'h8000, 16'h8000, 1, 3, 1));
    // Whole window visited
    dir_rows.push_back(row_query(16'h0000, 16'h0000, 1, 0, 0));
    // Reloading an entry clears its mark
    dir_rows.push_back(row_load(0, 16'h0000, 16'h0000));
    dir_rows.push_back(row_query(16'hFFFF, 16'hFFFF, 1, 0, 1));
    dir_rows.push_back(row_load(2, 16'h0007, 16'h0009));
    dir_rows.push_back(row_load(1, 16'h0007, 16'h0009));
    dir_rows.push_back(row_query(16'h0000, 16'h0000, 0, 0, 0));
    dir_rows.push_back(row_query(16'h0007, 16'h0009, 0, 0, 0));
    dir_rows.push_back(row_cfg(1));
    dir_rows.push_back(row_query(16'h0001, 16'h0001, 0, 0, 0));
    dir_rows.push_back(row_load(0, 16'h0005, 16'h0005));
    dir_rows.push_back(row_query(16'h0001, 16'h0001, 0, 0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_cell_count(dir_rows[i].count);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp);
    end

    // Fill the whole table so that any window, up to the saturated one, is defined
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      fill = '{req_type: REQ_LOAD, entry_index: 6'(i),
               point_x: rand_coord(), point_y: rand_coord()};
      send_item(fill, 1'b0, '0);
    end

    // Random phases: each picks a count setting and an idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       n = 7'd64;
        1:       n = 7'd127;
        2:       n = 7'd1;
        3:       n = 7'd0;
        4:       n = 7'($urandom_range(2, 63));
        5:       n = 7'($urandom_range(65, 126));
        6:       n = 7'd64;
        default: n = 7'($urandom_range(1, 64));
      endcase
      set_cell_count(n);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      repeat (PHASE_ITEMS) send_item(rand_item(), 1'b0, '0);
    end

    // Drain: hold valid low until every match item is back, then let the engine settle
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_matches.size() != 0)
      report_mismatch($sformatf("%0d match items never arrived", pending_matches.size()));

    $display("Sent %0d items (%0d queries, %0d matched) across %0d count settings,",
             n_items, n_queries, n_found, n_settings);
    $display("with ties, saturated and empty windows and four idling patterns; %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
